@@ hdl/wnst_pkg.sv @@
// shared constants, codes and types for the weighted neighbour sorted table
package wnst_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int ID_BITS     = 16;
  localparam int WEIGHT_BITS = 16;
  localparam int OPND_BITS   = 16;
  localparam int TYPE_BITS   = 3;
  localparam int STATUS_BITS = 2;
  localparam int KEY_BITS    = WEIGHT_BITS + ID_BITS;
  localparam int IDX_BITS    = $clog2(TABLE_DEPTH + 1);

  // request codes
  localparam logic [TYPE_BITS-1:0] REQ_SET    = 3'd0;
  localparam logic [TYPE_BITS-1:0] REQ_ERASE  = 3'd1;
  localparam logic [TYPE_BITS-1:0] REQ_READ   = 3'd2;
  localparam logic [TYPE_BITS-1:0] REQ_BEST   = 3'd3;
  localparam logic [TYPE_BITS-1:0] REQ_THRESH = 3'd4;
  localparam logic [TYPE_BITS-1:0] REQ_CLEAR  = 3'd5;

  // status codes
  localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic                   valid;
    logic [WEIGHT_BITS-1:0] weight;
    logic [ID_BITS-1:0]     id;
  } entry_t;

  localparam entry_t NO_ENTRY = '{valid: 1'b0, weight: '0, id: '0};

  // operation broadcast to every cell of the chain
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_CLEAR,
    CELL_LOAD,
    CELL_SHIFT
  } cell_op_t;

  typedef struct packed {
    cell_op_t            op;
    entry_t              new_ent;
    logic [KEY_BITS-1:0] hit_key;
  } cell_cmd_t;

  // sort key: weight first, then id
  function automatic logic [KEY_BITS-1:0] entry_key(entry_t e);
    return {e.weight, e.id};
  endfunction

endpackage

@@ hdl/wnst_cell.sv @@
// one cell of the sorted chain: a table entry plus a read-out stage
module wnst_cell import wnst_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cell_cmd_t cmd,
  input  entry_t    prev_ent,
  input  logic      prev_ins,
  input  entry_t    next_ent,
  input  entry_t    next_strm,
  output entry_t    ent,
  output logic      ins,
  output logic      match,
  output entry_t    strm
);

  logic rem;

  // new entry ranks ahead of this one (or this cell is empty)
  assign ins   = !ent.valid || (entry_key(cmd.new_ent) > entry_key(ent));
  // this entry is the one being removed or sits behind it
  assign rem   = ent.valid && (entry_key(ent) <= cmd.hit_key);
  assign match = ent.valid && (ent.id == cmd.new_ent.id);

  // entry and read-out registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid  <= 1'b0;
      strm.valid <= 1'b0;
    end else begin
      case (cmd.op)
        CELL_INSERT: begin
          if (ins) begin
            ent <= prev_ins ? prev_ent : cmd.new_ent;
          end
        end
        CELL_REMOVE: begin
          if (rem) begin
            ent <= next_ent;
          end
        end
        CELL_CLEAR: begin
          ent.valid <= 1'b0;
        end
        CELL_LOAD: begin
          strm <= ent;
        end
        CELL_SHIFT: begin
          strm <= next_strm;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

@@ hdl/weighted_neighbor_sorted_table_core.sv @@
// top level: request sequencer, chain of sorted cells and output register
// each request passes the look state; a set or erase that hits then removes the old entry,
// a set not dropped as full inserts, and a response or stream state fills the output register
// stream beats follow one per cycle from the head of the read-out chain, unless stalled
// a new request is taken only when the sequencer is idle; unused codes go one per cycle
// reset clears every valid bit; no clearing pass is needed
module weighted_neighbor_sorted_table_core import wnst_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [TYPE_BITS-1:0]   req_type,
  input  logic [ID_BITS-1:0]     neighbor_id,
  input  logic [OPND_BITS-1:0]   operand_value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [ID_BITS-1:0]     out_id,
  output logic [WEIGHT_BITS-1:0] out_weight,
  output logic [STATUS_BITS-1:0] status,
  output logic                   last
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_REMOVE,
    S_INSERT,
    S_RESP,
    S_STREAM
  } state_t;

  state_t                 state;
  logic [TYPE_BITS-1:0]   req_q;
  logic [ID_BITS-1:0]     id_q;
  logic [OPND_BITS-1:0]   opnd_q;
  logic                   hit;
  logic [WEIGHT_BITS-1:0] hit_w;
  logic                   drop;
  logic [IDX_BITS-1:0]    idx;

  cell_cmd_t              cmd;
  entry_t                 ent  [TABLE_DEPTH];
  entry_t                 strm [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] ins_vec;
  logic [TABLE_DEPTH-1:0] match_vec;
  logic [TABLE_DEPTH-1:0] valid_vec;
  logic [TABLE_DEPTH-2:0] order_ok;

  logic                   hit_any;
  logic [WEIGHT_BITS-1:0] hit_w_c;
  logic                   full;
  logic                   go;
  logic                   beat_load;
  logic                   is_best;
  logic [IDX_BITS-1:0]    idx_p1;
  logic                   q0;
  logic                   q1;

  assign in_stall  = (state != S_IDLE);
  assign go        = !out_valid || !out_stall;
  assign beat_load = go && ((state == S_RESP) || (state == S_STREAM));
  assign full      = ent[TABLE_DEPTH-1].valid;
  assign is_best   = (req_q == REQ_BEST);
  assign idx_p1    = idx + 1'b1;

  // chain of cells
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    entry_t prev_e;
    entry_t next_e;
    entry_t next_s;
    logic   prev_i;
    if (i == 0) begin : g_head
      assign prev_e = NO_ENTRY;
      assign prev_i = 1'b0;
    end else begin : g_mid
      assign prev_e = ent[i-1];
      assign prev_i = ins_vec[i-1];
    end
    if (i == TABLE_DEPTH - 1) begin : g_tail
      assign next_e = NO_ENTRY;
      assign next_s = NO_ENTRY;
    end else begin : g_body
      assign next_e = ent[i+1];
      assign next_s = strm[i+1];
    end
    wnst_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .prev_ent  (prev_e),
      .prev_ins  (prev_i),
      .next_ent  (next_e),
      .next_strm (next_s),
      .ent       (ent[i]),
      .ins       (ins_vec[i]),
      .match     (match_vec[i]),
      .strm      (strm[i])
    );
    assign valid_vec[i] = ent[i].valid;
    if (i < TABLE_DEPTH - 1) begin : g_ord
      assign order_ok[i] = !ent[i+1].valid ||
                           (entry_key(ent[i]) > entry_key(ent[i+1]));
    end
  end

  // lookup: at most one cell matches, so an or of gated weights picks it
  always_comb begin
    hit_w_c = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      hit_w_c = hit_w_c | (match_vec[i] ? ent[i].weight : '0);
    end
  end
  assign hit_any = |match_vec;

  // stream qualification of the head and the entry behind it
  assign q0 = strm[0].valid && (is_best ?
              ({{(OPND_BITS-IDX_BITS){1'b0}}, idx} < opnd_q) :
              (strm[0].weight >= opnd_q[WEIGHT_BITS-1:0]));
  assign q1 = strm[1].valid && (is_best ?
              ({{(OPND_BITS-IDX_BITS){1'b0}}, idx_p1} < opnd_q) :
              (strm[1].weight >= opnd_q[WEIGHT_BITS-1:0]));

  // command to the cells
  always_comb begin
    cmd.new_ent = '{valid: 1'b1, weight: opnd_q[WEIGHT_BITS-1:0], id: id_q};
    cmd.hit_key = {hit_w, id_q};
    cmd.op      = CELL_HOLD;
    case (state)
      S_LOOK: begin
        if (req_q == REQ_CLEAR) begin
          cmd.op = CELL_CLEAR;
        end else if (req_q == REQ_BEST || req_q == REQ_THRESH) begin
          cmd.op = CELL_LOAD;
        end
      end
      S_REMOVE: cmd.op = CELL_REMOVE;
      S_INSERT: cmd.op = CELL_INSERT;
      S_STREAM: begin
        if (go && q0) begin
          cmd.op = CELL_SHIFT;
        end
      end
      default: cmd.op = CELL_HOLD;
    endcase
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (beat_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && (req_type inside {[REQ_SET:REQ_CLEAR]})) begin
            req_q  <= req_type;
            id_q   <= neighbor_id;
            opnd_q <= operand_value;
            state  <= S_LOOK;
          end
        end
        S_LOOK: begin
          hit   <= hit_any;
          hit_w <= hit_w_c;
          drop  <= !hit_any && full;
          idx   <= '0;
          case (req_q)
            REQ_SET:    state <= hit_any ? S_REMOVE : (full ? S_RESP : S_INSERT);
            REQ_ERASE:  state <= hit_any ? S_REMOVE : S_RESP;
            REQ_READ:   state <= S_RESP;
            REQ_BEST:   state <= S_STREAM;
            REQ_THRESH: state <= S_STREAM;
            REQ_CLEAR:  state <= S_RESP;
            default:    state <= S_IDLE;
          endcase
        end
        S_REMOVE: begin
          state <= (req_q == REQ_SET) ? S_INSERT : S_RESP;
        end
        S_INSERT: begin
          state <= S_RESP;
        end
        S_RESP: begin
          if (go) begin
            last      <= 1'b1;
            state     <= S_IDLE;
            case (req_q)
              REQ_SET: begin
                out_id     <= id_q;
                out_weight <= opnd_q[WEIGHT_BITS-1:0];
                status     <= drop ? ST_FULL : ST_OK;
              end
              REQ_ERASE: begin
                out_id     <= id_q;
                out_weight <= '0;
                status     <= hit ? ST_OK : ST_EMPTY;
              end
              REQ_READ: begin
                out_id     <= id_q;
                out_weight <= hit ? hit_w : '0;
                status     <= hit ? ST_OK : ST_EMPTY;
              end
              default: begin
                out_id     <= '0;
                out_weight <= '0;
                status     <= ST_OK;
              end
            endcase
          end
        end
        S_STREAM: begin
          if (go) begin
            if (!q0) begin
              // nothing selected: one empty beat
              out_id     <= '0;
              out_weight <= '0;
              status     <= ST_EMPTY;
              last       <= 1'b1;
              state      <= S_IDLE;
            end else begin
              out_id     <= strm[0].id;
              out_weight <= strm[0].weight;
              status     <= ST_OK;
              last       <= !q1;
              idx        <= idx_p1;
              if (!q1) begin
                state <= S_IDLE;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // valid entries fill the chain from the head without gaps
  a_packed: assert property (@(posedge clk) disable iff (rst)
    (valid_vec & (valid_vec + 1'b1)) == '0)
    else $error("table entries not packed from the head");

  // entries stay strictly ordered by weight then id
  a_sorted: assert property (@(posedge clk) disable iff (rst)
    &order_ok)
    else $error("table order broken");

  // ids are unique, so a lookup hits at most one cell
  a_unique: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOOK) |-> $onehot0(match_vec))
    else $error("id found in more than one cell");
`endif

endmodule

@@ verif/tb_top.sv @@
// testbench for the weighted neighbour sorted table: directed table, random requests, checker
module tb_top;
  import wnst_pkg::*;

  // request codes the block ignores
  localparam logic [TYPE_BITS-1:0] REQ_SPARE6 = 3'd6;
  localparam logic [TYPE_BITS-1:0] REQ_SPARE7 = 3'd7;

  localparam int FILL_ITEMS  = 55;
  localparam int MIX_ITEMS   = 40;
  localparam int CALM_ITEMS  = 15;
  localparam int HOLD_CYCLES = 250;
  localparam int HOLD_AFTER  = 45;
  localparam int TAIL_CYCLES = 20;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic [ID_BITS-1:0]     id;
    logic [WEIGHT_BITS-1:0] wt;
    logic [STATUS_BITS-1:0] st;
    logic                   tail;
  } beat_t;

  typedef struct packed {
    logic [TYPE_BITS-1:0] rq;
    logic [ID_BITS-1:0]   nid;
    logic [OPND_BITS-1:0] opv;
    logic                 typed;
    beat_t                want;
  } row_t;

  localparam beat_t NO_BEAT = '0;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [TYPE_BITS-1:0]   req_type = '0;
  logic [ID_BITS-1:0]     neighbor_id = '0;
  logic [OPND_BITS-1:0]   operand_value = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [ID_BITS-1:0]     out_id;
  logic [WEIGHT_BITS-1:0] out_weight;
  logic [STATUS_BITS-1:0] status;
  logic                   last;

  // predicted table contents, kept sorted like the block
  logic [ID_BITS-1:0]     nbr_id [TABLE_DEPTH];
  logic [WEIGHT_BITS-1:0] nbr_wt [TABLE_DEPTH];
  int                     nbr_cnt = 0;

  beat_t due_beats [$];
  row_t  drill [$];
  beat_t oldest;

  int  err_cnt     = 0;
  int  beats_seen  = 0;
  int  reqs_sent   = 0;
  int  full_drops  = 0;
  int  peak_fill   = 0;
  int  idle_cycles = 0;
  bit  calm        = 1'b0;
  bit  held_off    = 1'b0;

  weighted_neighbor_sorted_table_core dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .req_type      (req_type),
    .neighbor_id   (neighbor_id),
    .operand_value (operand_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_id        (out_id),
    .out_weight    (out_weight),
    .status        (status),
    .last          (last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic beat_t mk_beat(logic [ID_BITS-1:0] id, logic [WEIGHT_BITS-1:0] wt,
                                    logic [STATUS_BITS-1:0] st, logic tail);
    beat_t b;
    b.id   = id;
    b.wt   = wt;
    b.st   = st;
    b.tail = tail;
    return b;
  endfunction

  // append one beat to the expected queue
  task automatic due_add(input beat_t b);
    due_beats = {due_beats, b};
  endtask

  function automatic int nbr_find(logic [ID_BITS-1:0] nid);
    for (int i = 0; i < nbr_cnt; i++)
      if (nbr_id[i] == nid) return i;
    return -1;
  endfunction

  // close the gap left by a removed entry
  task automatic nbr_remove(input int pos);
    for (int i = pos; i + 1 < nbr_cnt; i++) begin
      nbr_id[i] = nbr_id[i+1];
      nbr_wt[i] = nbr_wt[i+1];
    end
    nbr_cnt--;
  endtask

  // insert by weight descending, then id descending
  task automatic nbr_insert(input logic [ID_BITS-1:0] nid, input logic [WEIGHT_BITS-1:0] w);
    int pos;
    pos = 0;
    while (pos < nbr_cnt && (nbr_wt[pos] > w || (nbr_wt[pos] == w && nbr_id[pos] > nid)))
      pos++;
    for (int i = nbr_cnt; i > pos; i--) begin
      nbr_id[i] = nbr_id[i-1];
      nbr_wt[i] = nbr_wt[i-1];
    end
    nbr_id[pos] = nid;
    nbr_wt[pos] = w;
    nbr_cnt++;
    if (nbr_cnt > peak_fill) peak_fill = nbr_cnt;
  endtask

  // update the predicted table and queue the beats one request should give
  task automatic nbr_answer(input logic [TYPE_BITS-1:0] rq, input logic [ID_BITS-1:0] nid,
                            input logic [OPND_BITS-1:0] opv);
    int pos;
    int n;
    logic [WEIGHT_BITS-1:0] w;
    w = opv[WEIGHT_BITS-1:0];
    pos = nbr_find(nid);
    n = 0;
    case (rq)
      REQ_SET: begin
        if (pos >= 0) begin
          nbr_remove(pos);
          nbr_insert(nid, w);
          due_add(mk_beat(nid, w, ST_OK, 1'b1));
        end else if (nbr_cnt < TABLE_DEPTH) begin
          nbr_insert(nid, w);
          due_add(mk_beat(nid, w, ST_OK, 1'b1));
        end else begin
          full_drops++;
          due_add(mk_beat(nid, w, ST_FULL, 1'b1));
        end
      end
      REQ_ERASE: begin
        if (pos >= 0) begin
          nbr_remove(pos);
          due_add(mk_beat(nid, '0, ST_OK, 1'b1));
        end else begin
          due_add(mk_beat(nid, '0, ST_EMPTY, 1'b1));
        end
      end
      REQ_READ: begin
        if (pos >= 0) due_add(mk_beat(nid, nbr_wt[pos], ST_OK, 1'b1));
        else due_add(mk_beat(nid, '0, ST_EMPTY, 1'b1));
      end
      REQ_BEST, REQ_THRESH: begin
        if (rq == REQ_BEST) begin
          n = (opv < nbr_cnt) ? int'(opv) : nbr_cnt;
        end else begin
          while (n < nbr_cnt && nbr_wt[n] >= w) n++;
        end
        if (n == 0) due_add(mk_beat('0, '0, ST_EMPTY, 1'b1));
        for (int i = 0; i < n; i++)
          due_add(mk_beat(nbr_id[i], nbr_wt[i], ST_OK, i == n - 1));
      end
      REQ_CLEAR: begin
        nbr_cnt = 0;
        due_add(mk_beat('0, '0, ST_OK, 1'b1));
      end
      default: ;
    endcase
  endtask

  task automatic add_row(input logic [TYPE_BITS-1:0] rq, input logic [ID_BITS-1:0] nid,
                         input logic [OPND_BITS-1:0] opv, input logic typed,
                         input logic [ID_BITS-1:0] eid, input logic [WEIGHT_BITS-1:0] ewt,
                         input logic [STATUS_BITS-1:0] est);
    row_t r;
    r.rq    = rq;
    r.nid   = nid;
    r.opv   = opv;
    r.typed = typed;
    r.want  = mk_beat(eid, ewt, est, 1'b1);
    drill = {drill, r};
  endtask

  // drive one request beat from a falling edge and wait until it is taken
  task automatic offer(input logic [TYPE_BITS-1:0] rq, input logic [ID_BITS-1:0] nid,
                       input logic [OPND_BITS-1:0] opv, input logic typed, input beat_t want);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_valid      = 1'b1;
    req_type      = rq;
    neighbor_id   = nid;
    operand_value = opv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    nbr_answer(rq, nid, opv);
    // fixed rows give one beat, typed in by hand
    if (typed) begin
      void'(due_beats.pop_back());
      due_add(want);
    end
    reqs_sent++;
    @(negedge clk);
  endtask

  function automatic logic [WEIGHT_BITS-1:0] pick_weight();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return WEIGHT_BITS'($urandom_range(0, 7));
    if (r < 50) return WEIGHT_BITS'(16'hFFF8 + $urandom_range(0, 7));
    return WEIGHT_BITS'($urandom());
  endfunction

  // filling: mostly sets of fresh ids until the table overflows
  task automatic random_request(input bit filling);
    int roll;
    logic [TYPE_BITS-1:0] rq;
    logic [ID_BITS-1:0]   nid;
    logic [OPND_BITS-1:0] opv;
    roll = $urandom_range(0, 99);
    if (filling) begin
      if (roll < 90) rq = REQ_SET;
      else if (roll < 94) rq = REQ_READ;
      else if (roll < 97) rq = REQ_BEST;
      else rq = REQ_THRESH;
    end else begin
      if (roll < 35) rq = REQ_SET;
      else if (roll < 50) rq = REQ_ERASE;
      else if (roll < 65) rq = REQ_READ;
      else if (roll < 77) rq = REQ_BEST;
      else if (roll < 89) rq = REQ_THRESH;
      else if (roll < 93) rq = REQ_CLEAR;
      else if (roll < 96) rq = REQ_SPARE6;
      else rq = REQ_SPARE7;
    end
    if (nbr_cnt > 0 && $urandom_range(0, 99) < (filling ? 15 : 50))
      nid = nbr_id[$urandom_range(0, nbr_cnt - 1)];
    else
      nid = ID_BITS'($urandom());
    roll = $urandom_range(0, 99);
    case (rq)
      REQ_BEST: begin
        if (roll < 70) opv = OPND_BITS'($urandom_range(0, nbr_cnt + 2));
        else if (roll < 85) opv = OPND_BITS'($urandom_range(31, 33));
        else opv = OPND_BITS'($urandom());
      end
      REQ_THRESH: begin
        if (roll < 50 && nbr_cnt > 0) opv = nbr_wt[$urandom_range(0, nbr_cnt - 1)];
        else if (roll < 60) opv = '0;
        else opv = pick_weight();
      end
      default: opv = pick_weight();
    endcase
    offer(rq, nid, opv, 1'b0, NO_BEAT);
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      beats_seen++;
      if (due_beats.size() == 0) begin
        $error("unexpected beat: id %h weight %h status %0d", out_id, out_weight, status);
        err_cnt++;
      end else begin
        oldest = due_beats.pop_front();
        if (out_id !== oldest.id) begin
          $error("out_id: expected %h, got %h", oldest.id, out_id);
          err_cnt++;
        end
        if (out_weight !== oldest.wt) begin
          $error("out_weight: expected %h, got %h", oldest.wt, out_weight);
          err_cnt++;
        end
        if (status !== oldest.st) begin
          $error("status: expected %0d, got %0d", oldest.st, status);
          err_cnt++;
        end
        if (last !== oldest.tail) begin
          $error("last: expected %0d, got %0d", oldest.tail, last);
          err_cnt++;
        end
      end
    end
  end

  // receiver: random stall bursts, one long hold-off while requests keep coming
  initial begin
    forever begin
      @(negedge clk);
      if (!held_off && beats_seen >= HOLD_AFTER) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall = 1'b0;
        held_off  = 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 15)) @(negedge clk);
        out_stall = 1'b0;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // watchdog on cycles with no beat moving on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("tb_top: done, errors");
    $finish;
  end

  // stimulus
  initial begin
    // empty table answers
    add_row(REQ_READ,   16'h0005, 16'h0000, 1'b1, 16'h0005, 16'h0000, ST_EMPTY);
    add_row(REQ_BEST,   16'h0000, 16'h0003, 1'b1, 16'h0000, 16'h0000, ST_EMPTY);
    add_row(REQ_THRESH, 16'h0000, 16'h0000, 1'b1, 16'h0000, 16'h0000, ST_EMPTY);
    add_row(REQ_ERASE,  16'h0007, 16'h0000, 1'b1, 16'h0007, 16'h0000, ST_EMPTY);
    // extremes, a weight tie and a replace
    add_row(REQ_SET,    16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF, ST_OK);
    add_row(REQ_SET,    16'h0000, 16'h0000, 1'b1, 16'h0000, 16'h0000, ST_OK);
    add_row(REQ_SET,    16'h1234, 16'h0100, 1'b1, 16'h1234, 16'h0100, ST_OK);
    add_row(REQ_SET,    16'h1233, 16'h0100, 1'b1, 16'h1233, 16'h0100, ST_OK);
    add_row(REQ_SET,    16'h1234, 16'h0001, 1'b1, 16'h1234, 16'h0001, ST_OK);
    add_row(REQ_READ,   16'h1234, 16'h0000, 1'b1, 16'h1234, 16'h0001, ST_OK);
    add_row(REQ_READ,   16'h0000, 16'hFFFF, 1'b1, 16'h0000, 16'h0000, ST_OK);
    // streams
    add_row(REQ_BEST,   16'h0000, 16'hFFFF, 1'b0, '0, '0, ST_OK);
    add_row(REQ_BEST,   16'h0000, 16'h0000, 1'b1, 16'h0000, 16'h0000, ST_EMPTY);
    add_row(REQ_BEST,   16'hFFFF, 16'h0002, 1'b0, '0, '0, ST_OK);
    add_row(REQ_THRESH, 16'h0000, 16'h0000, 1'b0, '0, '0, ST_OK);
    add_row(REQ_THRESH, 16'h0000, 16'hFFFF, 1'b0, '0, '0, ST_OK);
    add_row(REQ_THRESH, 16'h0000, 16'h0100, 1'b0, '0, '0, ST_OK);
    // ignored codes give nothing
    add_row(REQ_SPARE6, 16'hFFFF, 16'hFFFF, 1'b0, '0, '0, ST_OK);
    add_row(REQ_SPARE7, 16'h0000, 16'h0000, 1'b0, '0, '0, ST_OK);
    // erase hit then miss, tie on top weight, clear
    add_row(REQ_ERASE,  16'h1233, 16'h0000, 1'b1, 16'h1233, 16'h0000, ST_OK);
    add_row(REQ_ERASE,  16'h1233, 16'h0000, 1'b1, 16'h1233, 16'h0000, ST_EMPTY);
    add_row(REQ_SET,    16'hABCD, 16'hFFFF, 1'b0, '0, '0, ST_OK);
    add_row(REQ_CLEAR,  16'h0000, 16'h0000, 1'b1, 16'h0000, 16'h0000, ST_OK);
    add_row(REQ_BEST,   16'h0000, 16'hFFFF, 1'b1, 16'h0000, 16'h0000, ST_EMPTY);
    add_row(REQ_READ,   16'hFFFF, 16'h0000, 1'b1, 16'hFFFF, 16'h0000, ST_EMPTY);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (drill[k])
      offer(drill[k].rq, drill[k].nid, drill[k].opv, drill[k].typed, drill[k].want);

    for (int k = 0; k < FILL_ITEMS; k++) random_request(1'b1);

    // let the block drain completely before the mixed phase
    in_valid = 1'b0;
    wait (due_beats.size() == 0);
    @(negedge clk);

    for (int k = 0; k < MIX_ITEMS; k++) begin
      calm = (k >= MIX_ITEMS - CALM_ITEMS);
      random_request(1'b0);
    end
    in_valid = 1'b0;

    wait (due_beats.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("tb_top: %0d requests, %0d beats checked, peak fill %0d of %0d, %0d full drops",
             reqs_sent, beats_seen, peak_fill, TABLE_DEPTH, full_drops);
    $display("tb_top: random stalls both sides, one long receiver hold, one full drain pause");
    if (err_cnt == 0 && due_beats.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
